### src/dq_pkg.sv
// Package for the double-ended queue: request and result payload types,
// operation codes and the command passed from the front end to the back end.
// No dependencies.
`default_nettype none

package dq_pkg;

    localparam int SLOT_W = 6;
    localparam int SIZE_W = 7;

    typedef enum logic [2:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_RESIZE    = 3'd4,
        OP_READ      = 3'd5,
        OP_WRITE     = 3'd6,
        OP_DUMP      = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [6:0]         new_size;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] data;
        logic               is_last;
        logic               error;
        logic [6:0]         size_now;
    } t_out_item;

    // What the back end must do with one queued command.
    typedef enum logic [1:0] {
        CMD_RESULT = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               is_last;
        logic               error;
        logic [SIZE_W-1:0]  size_now;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

endpackage

`default_nettype wire

### src/dq_front.sv
// Front end of the double-ended queue: accepts requests, keeps the front
// pointer and element count, and turns each request into a back-end command.
// Depends on dq_pkg.
`default_nettype none

module dq_front #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire dq_pkg::t_in_item      i_in,
    input  wire logic                  i_fifo_full,
    output logic                       o_push,
    output dq_pkg::t_cmd               o_cmd,
    output logic [DATA_WIDTH-1:0]      o_cmd_data
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          accept;
    logic          full;
    logic          empty;
    logic          pos_ok;
    logic [PW:0]   sum_pos;
    logic [PW:0]   sum_back;
    logic [PW-1:0] slot_pos;
    logic [PW-1:0] slot_back;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] front_inc;
    logic [EXT_W-1:0] value_ext;
    dq_pkg::t_cmd  cmd;
    logic          drop;

    assign o_in_ready = !i_fifo_full;
    assign accept     = i_in_valid && o_in_ready;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign pos_ok = ({1'b0, i_in.position} < 7'(r_count));

    // The front pointer is below DEPTH and the other addend at most DEPTH, so one conditional subtract wraps the sum.
    assign sum_pos   = {1'b0, r_front} + (PW + 1)'(i_in.position);
    assign sum_back  = {1'b0, r_front} + (PW + 1)'(r_count);
    assign slot_pos  = (sum_pos  >= DEPTH_P) ? PW'(sum_pos  - DEPTH_P) : PW'(sum_pos);
    assign slot_back = (sum_back >= DEPTH_P) ? PW'(sum_back - DEPTH_P) : PW'(sum_back);
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;

    assign value_ext  = EXT_W'(i_in.value);
    assign o_cmd_data = value_ext[DATA_WIDTH-1:0];

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        drop         = 1'b0;
        cmd.kind     = dq_pkg::CMD_RESULT;
        cmd.is_last  = 1'b0;
        cmd.error    = 1'b0;
        cmd.slot     = '0;
        case (dq_pkg::t_opcode'(i_in.opcode))
            dq_pkg::OP_PUSH_TAIL: begin
                if (full) begin
                    cmd.error = 1'b1;
                end else begin
                    cmd.kind = dq_pkg::CMD_WRITE;
                    cmd.slot = dq_pkg::SLOT_W'(slot_back);
                    n_count  = r_count + 1'b1;
                end
            end
            dq_pkg::OP_PUSH_HEAD: begin
                if (full) begin
                    cmd.error = 1'b1;
                end else begin
                    cmd.kind = dq_pkg::CMD_WRITE;
                    cmd.slot = dq_pkg::SLOT_W'(front_dec);
                    n_front  = front_dec;
                    n_count  = r_count + 1'b1;
                end
            end
            dq_pkg::OP_POP_HEAD: begin
                if (empty) begin
                    cmd.error = 1'b1;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::OP_POP_TAIL: begin
                if (empty) begin
                    cmd.error = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            dq_pkg::OP_RESIZE: begin
                if (i_in.new_size > 7'(DEPTH)) begin
                    cmd.error = 1'b1;
                end else begin
                    n_count = CW'(i_in.new_size);
                end
            end
            dq_pkg::OP_READ: begin
                cmd.is_last = 1'b1;
                if (!pos_ok) begin
                    cmd.error = 1'b1;
                end else begin
                    cmd.kind = dq_pkg::CMD_READ;
                    cmd.slot = dq_pkg::SLOT_W'(slot_pos);
                end
            end
            dq_pkg::OP_WRITE: begin
                if (!pos_ok) begin
                    cmd.error = 1'b1;
                end else begin
                    cmd.kind = dq_pkg::CMD_WRITE;
                    cmd.slot = dq_pkg::SLOT_W'(slot_pos);
                end
            end
            default: begin
                // Dump: the back end walks the elements from the current front.
                cmd.kind = dq_pkg::CMD_DUMP;
                cmd.slot = dq_pkg::SLOT_W'(r_front);
                drop     = empty;
            end
        endcase
        cmd.size_now = dq_pkg::SIZE_W'(n_count);
    end

    assign o_cmd  = cmd;
    assign o_push = accept && !drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### src/dq_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on dq_pkg.
`default_nettype none

module dq_cmd_fifo #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire dq_pkg::t_cmd          i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_full,
    output logic                       o_valid,
    input  wire logic                  i_pop,
    output dq_pkg::t_cmd               o_cmd,
    output logic [DATA_WIDTH-1:0]      o_data
);

    dq_pkg::t_cmd          r_cmd  [2];
    logic [DATA_WIDTH-1:0] r_data [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_fill;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### src/dq_back.sv
// Back end of the double-ended queue: owns the element store, carries out
// queued commands and drives the registered result channel.
// Depends on dq_pkg.
`default_nettype none

module dq_back #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire dq_pkg::t_cmd          i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_cmd_data,
    output logic                       o_cmd_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output dq_pkg::t_out_item          o_out
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_DUMP = 2'd2
    } t_back_state;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      r_written;

    t_back_state           r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    dq_pkg::t_out_item     r_out, n_out;
    logic [dq_pkg::SIZE_W-1:0] r_size, n_size;
    logic [CW-1:0]         r_left, n_left;
    logic [PW-1:0]         r_slot, n_slot;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld;

    logic                  out_free;
    logic                  mem_we;
    logic                  rd_en;
    logic [PW-1:0]         rd_addr;
    logic [PW-1:0]         cmd_slot;
    logic [PW-1:0]         cmd_slot_inc;
    logic [PW-1:0]         slot_inc;
    logic [EXT_W-1:0]      rd_ext;
    logic [31:0]           rd_value;

    assign out_free     = !r_out_valid || i_out_ready;
    assign cmd_slot     = i_cmd.slot[PW-1:0];
    assign cmd_slot_inc = (cmd_slot == LAST_SLOT) ? '0 : cmd_slot + 1'b1;
    assign slot_inc     = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign rd_ext       = EXT_W'($signed(r_rd_data));
    // A slot never written since reset reads as zero.
    assign rd_value     = r_rd_vld ? rd_ext[31:0] : 32'd0;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_size      = r_size;
        n_left      = r_left;
        n_slot      = r_slot;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = cmd_slot;
        o_cmd_pop   = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    n_size    = i_cmd.size_now;
                    case (i_cmd.kind)
                        dq_pkg::CMD_READ: begin
                            rd_en   = 1'b1;
                            n_state = BK_READ;
                        end
                        dq_pkg::CMD_DUMP: begin
                            rd_en   = 1'b1;
                            n_left  = CW'(i_cmd.size_now);
                            n_slot  = cmd_slot_inc;
                            n_state = BK_DUMP;
                        end
                        default: begin
                            mem_we         = (i_cmd.kind == dq_pkg::CMD_WRITE);
                            n_out.data     = '0;
                            n_out.is_last  = i_cmd.is_last;
                            n_out.error    = i_cmd.error;
                            n_out.size_now = i_cmd.size_now;
                            n_out_valid    = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                if (out_free) begin
                    n_out.data     = rd_value;
                    n_out.is_last  = 1'b1;
                    n_out.error    = 1'b0;
                    n_out.size_now = r_size;
                    n_out_valid    = 1'b1;
                    n_state        = BK_IDLE;
                end
            end
            BK_DUMP: begin
                if (out_free) begin
                    n_out.data     = rd_value;
                    n_out.is_last  = (r_left == CW'(1));
                    n_out.error    = 1'b0;
                    n_out.size_now = r_size;
                    n_out_valid    = 1'b1;
                    if (r_left == CW'(1)) begin
                        n_state = BK_IDLE;
                    end else begin
                        // Fetch the next element while this one is shown.
                        rd_en   = 1'b1;
                        rd_addr = r_slot;
                        n_slot  = slot_inc;
                        n_left  = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_size <= n_size;
        r_left <= n_left;
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (mem_we) begin
            r_written[cmd_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[cmd_slot] <= i_cmd_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_written[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### src/double_ended_queue.sv
// Top level of the double-ended queue: front end, command queue, back end.
// Depends on dq_pkg, dq_front, dq_cmd_fifo and dq_back.
//
//   channel   direction  valid        ready        payload
//   request   in         i_in_valid   o_in_ready   i_in  (dq_pkg::t_in_item)
//   result    out        o_out_valid  i_out_ready  o_out (dq_pkg::t_out_item)
//
// A single operation passes from request to result through its command queue
// entry and then the back end's result register. A read and the start of a
// dump also pass through the store's registered read port; a dump of N
// elements then streams N results, one per cycle while the result channel is
// ready. Reset clears the pointer, the count and the written flags of all
// slots; requests are taken from the first cycle after reset.
// The front end keeps taking requests while the back end stalls, until the
// two-entry command queue is full.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dq_pkg::t_in_item  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dq_pkg::t_out_item      o_out
);

    logic                  push;
    logic                  fifo_full;
    dq_pkg::t_cmd          front_cmd;
    logic [DATA_WIDTH-1:0] front_data;
    logic                  cmd_valid;
    logic                  cmd_pop;
    dq_pkg::t_cmd          back_cmd;
    logic [DATA_WIDTH-1:0] back_data;

    dq_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .o_cmd_data  (front_data)
    );

    dq_cmd_fifo #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_data  (front_data),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (back_cmd),
        .o_data  (back_data)
    );

    dq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .i_cmd_data  (back_data),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### src/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
`default_nettype none

module dq_checker #(
    parameter int DEPTH = 64
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire dq_pkg::t_in_item  i_in,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire dq_pkg::t_out_item o_out
);

    // A result that is not taken stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed before it was taken");

    // A stalled request stays offered with the same payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("request withdrawn or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A rejected request never carries element data.
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error |-> o_out.data == 32'd0)
        else $error("rejected request returned data");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.size_now <= 7'(DEPTH))
        else $error("element count above capacity");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
